>>> rtl/euler_camera_orientation_update_defines.svh
// Assertion macros shared by the camera block.
`ifndef EULER_CAMERA_ORIENTATION_UPDATE_DEFINES_SVH
`define EULER_CAMERA_ORIENTATION_UPDATE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ECOU_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("camera assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ECOU_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("camera assertion failed");

`endif

>>> rtl/ecou_pkg.sv
`default_nettype none
package ecou_pkg;

  localparam logic signed [33:0] DEG90  = 34'sd5898240;
  localparam logic signed [33:0] DEG89  = 34'sd5832704;
  localparam logic signed [33:0] DEG180 = 34'sd11796480;
  localparam logic signed [33:0] DEG360 = 34'sd23592960;
  localparam logic signed [31:0] YAW_RESET = -32'sd11796480;
  localparam logic signed [33:0] CORDIC_X0 = 34'sd652032874;
  localparam logic signed [15:0] VEC_ONE = 16'sd16384;
  localparam logic [13:0] ZOOM_MIN = 14'd256;
  localparam logic [13:0] ZOOM_MAX = 14'd11520;
  localparam logic [15:0] SPEED_RESET = 16'd640;
  localparam logic [15:0] SENS_RESET = 16'd6554;

  localparam logic [1:0] CMD_ROTATE = 2'd0;
  localparam logic [1:0] CMD_MOVE   = 2'd1;
  localparam logic [1:0] CMD_SCROLL = 2'd2;

  localparam logic [1:0] CFG_MOVE_SPEED = 2'd0;
  localparam logic [1:0] CFG_LOOK_SENS  = 2'd1;

  localparam logic [2:0] DIR_FWD   = 3'd0;
  localparam logic [2:0] DIR_BACK  = 3'd1;
  localparam logic [2:0] DIR_LEFT  = 3'd2;
  localparam logic [2:0] DIR_RIGHT = 3'd3;
  localparam logic [2:0] DIR_UP    = 3'd4;
  localparam logic [2:0] DIR_DOWN  = 3'd5;

  typedef enum logic [4:0] {
    ST_IDLE, ST_R_MX, ST_R_MY, ST_R_ADD, ST_R_WRAP, ST_R_CY, ST_R_WY, ST_R_WP,
    ST_R_P0, ST_R_P1, ST_R_P2, ST_R_P3, ST_R_VEC,
    ST_M_V, ST_M_X, ST_M_Y, ST_M_Z, ST_M_W, ST_ZOOM, ST_FIN
  } state_t;

  typedef struct packed {
    logic              start;
    logic signed [31:0] angle;
  } cordic_req_t;

  typedef struct packed {
    logic              done;
    logic signed [15:0] sin_v;
    logic signed [15:0] cos_v;
  } cordic_rsp_t;

  // Arctangent of 2^-i in degrees, Q8.24.
  function automatic logic signed [33:0] atan_deg(input logic [4:0] idx);
    case (idx)
      5'd0:  atan_deg = 34'sd754974720;
      5'd1:  atan_deg = 34'sd445687602;
      5'd2:  atan_deg = 34'sd235489088;
      5'd3:  atan_deg = 34'sd119537938;
      5'd4:  atan_deg = 34'sd60000934;
      5'd5:  atan_deg = 34'sd30029717;
      5'd6:  atan_deg = 34'sd15018523;
      5'd7:  atan_deg = 34'sd7509720;
      5'd8:  atan_deg = 34'sd3754917;
      5'd9:  atan_deg = 34'sd1877466;
      5'd10: atan_deg = 34'sd938734;
      5'd11: atan_deg = 34'sd469367;
      5'd12: atan_deg = 34'sd234684;
      5'd13: atan_deg = 34'sd117342;
      5'd14: atan_deg = 34'sd58671;
      5'd15: atan_deg = 34'sd29335;
      5'd16: atan_deg = 34'sd14668;
      5'd17: atan_deg = 34'sd7334;
      5'd18: atan_deg = 34'sd3667;
      5'd19: atan_deg = 34'sd1833;
      5'd20: atan_deg = 34'sd917;
      5'd21: atan_deg = 34'sd458;
      5'd22: atan_deg = 34'sd229;
      5'd23: atan_deg = 34'sd115;
      default: atan_deg = 34'sd0;
    endcase
  endfunction

  // Q2.14 product with rounding and saturation to plus or minus one.
  function automatic logic signed [15:0] vmul(input logic signed [49:0] p);
    logic signed [49:0] r;
    r = (p + 50'sd8192) >>> 14;
    if (r > 50'sd16384) vmul = VEC_ONE;
    else if (r < -50'sd16384) vmul = -VEC_ONE;
    else vmul = r[15:0];
  endfunction

endpackage
`default_nettype wire

>>> rtl/ecou_if.sv
`default_nettype none
interface ecou_in_if;
  logic              valid;
  logic              ready;
  logic [1:0]        command;
  logic signed [15:0] x_offset;
  logic signed [15:0] y_offset;
  logic              clamp_pitch;
  logic [2:0]        direction;
  logic [15:0]       delta_seconds;
  logic signed [15:0] scroll_amount;
  modport source(output valid, command, x_offset, y_offset, clamp_pitch, direction,
                 delta_seconds, scroll_amount, input ready);
  modport sink(input valid, command, x_offset, y_offset, clamp_pitch, direction,
               delta_seconds, scroll_amount, output ready);
endinterface

interface ecou_out_if;
  logic              valid;
  logic              ready;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;
  logic signed [15:0] front_x;
  logic signed [15:0] front_y;
  logic signed [15:0] front_z;
  logic signed [15:0] up_x;
  logic signed [15:0] up_y;
  logic signed [15:0] up_z;
  logic [13:0]       zoom_deg;
  logic              degenerate;
  modport source(output valid, pos_x, pos_y, pos_z, front_x, front_y, front_z,
                 up_x, up_y, up_z, zoom_deg, degenerate, input ready);
  modport sink(input valid, pos_x, pos_y, pos_z, front_x, front_y, front_z,
               up_x, up_y, up_z, zoom_deg, degenerate, output ready);
endinterface

interface ecou_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface
`default_nettype wire

>>> rtl/ecou_cordic.sv
`default_nettype none
module ecou_cordic
  import ecou_pkg::*;
#(
  parameter int STEPS = 16
) (
  input  wire         clk,
  input  wire         rst_n,
  input  cordic_req_t req,
  output cordic_rsp_t rsp
);

  localparam int CW = $clog2(STEPS);

  logic              busy_r;
  logic              done_r;
  logic [CW-1:0]     cnt_r;
  logic signed [33:0] x_r;
  logic signed [33:0] y_r;
  logic signed [33:0] z_r;
  logic              neg_r;

  logic signed [33:0] a_ext;
  logic signed [33:0] a_adj;
  logic              neg_in;
  logic signed [33:0] dx;
  logic signed [33:0] dy;
  logic signed [33:0] at;
  logic signed [33:0] xf;
  logic signed [33:0] yf;

  function automatic logic signed [15:0] sat_q14(input logic signed [33:0] v);
    logic signed [33:0] r;
    r = (v + 34'sd32768) >>> 16;
    if (r > 34'sd16384) sat_q14 = VEC_ONE;
    else if (r < -34'sd16384) sat_q14 = -VEC_ONE;
    else sat_q14 = r[15:0];
  endfunction

  always_comb begin
    a_ext = {{2{req.angle[31]}}, req.angle};
    a_adj = a_ext;
    neg_in = 1'b0;
    if (a_ext > DEG90) begin
      a_adj = a_ext - DEG180;
      neg_in = 1'b1;
    end else if (a_ext < -DEG90) begin
      a_adj = a_ext + DEG180;
      neg_in = 1'b1;
    end
    dx = y_r >>> cnt_r;
    dy = x_r >>> cnt_r;
    at = atan_deg(5'(cnt_r));
    xf = neg_r ? -x_r : x_r;
    yf = neg_r ? -y_r : y_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r <= '0;
      end else if (busy_r) begin
        if (cnt_r == CW'(STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      x_r <= CORDIC_X0;
      y_r <= '0;
      z_r <= a_adj <<< 8;
      neg_r <= neg_in;
    end else if (busy_r) begin
      if (!z_r[33]) begin
        x_r <= x_r - dx;
        y_r <= y_r + dy;
        z_r <= z_r - at;
      end else begin
        x_r <= x_r + dx;
        y_r <= y_r - dy;
        z_r <= z_r + at;
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.cos_v = sat_q14(xf);
  assign rsp.sin_v = sat_q14(yf);

endmodule
`default_nettype wire

>>> rtl/euler_camera_orientation_update.sv
// First-person camera: rotate, move and zoom items update yaw, pitch, position, zoom and the
// front, right and up vectors, and each item returns one result with the state after it. One
// item is worked on at a time. A rotate item repeats its angle wrap step until yaw and pitch
// are in range and runs the iterative CORDIC unit once for yaw and once for pitch; rotate and
// move items share the one multiplier. A finished result waits in an output register.
`default_nettype none
`include "euler_camera_orientation_update_defines.svh"
module euler_camera_orientation_update
  import ecou_pkg::*;
#(
  parameter int CORDIC_STEPS = 16
) (
  input wire         clk,
  input wire         rst_n,
  ecou_cfg_if.sink   cfg_ch,
  ecou_in_if.sink    in_ch,
  ecou_out_if.source out_ch
);

  state_t state_r, state_nxt;

  logic [15:0]       speed_r, sens_r;
  logic signed [15:0] xo_r, yo_r, scr_r;
  logic              clamp_r;
  logic [2:0]        dir_r;
  logic [15:0]       dt_r;

  logic signed [31:0] yaw_r, pitch_r;
  logic signed [31:0] pos_r [3];
  logic signed [15:0] fx_r, fy_r, fz_r, rx_r, rz_r, ux_r, uy_r, uz_r;
  logic [13:0]       zoom_r;

  logic signed [49:0] prod_r;
  logic signed [31:0] dx_r;
  logic [31:0]       vel_r;
  logic signed [33:0] yaw_t_r, pitch_t_r;
  logic signed [15:0] sy_r, cy_r, sp_r, cp_r, tfx_r, tfz_r, tux_r;

  logic              out_valid_r, out_degen_r;
  logic signed [31:0] out_px_r, out_py_r, out_pz_r;
  logic signed [15:0] out_fx_r, out_fy_r, out_fz_r, out_ux_r, out_uy_r, out_uz_r;
  logic [13:0]       out_zoom_r;

  logic signed [16:0] mul_a;
  logic signed [32:0] mul_b;
  logic signed [49:0] rnd4;
  logic signed [33:0] psum;
  logic signed [33:0] pclip;
  logic              yaw_ok, pitch_ok;
  logic signed [15:0] mvx, mvy, mvz, uz_v;
  logic              mneg;
  logic signed [17:0] zs;
  logic              load_out;
  cordic_req_t       creq;
  cordic_rsp_t       crsp;

  function automatic logic signed [31:0] pos_step(input logic signed [31:0] p,
                                                  input logic signed [49:0] m,
                                                  input logic neg);
    logic signed [49:0] st;
    logic signed [33:0] pe;
    logic signed [33:0] s;
    st = (m + 50'sd2097152) >>> 22;
    pe = {{2{p[31]}}, p};
    s = neg ? pe - $signed(st[33:0]) : pe + $signed(st[33:0]);
    if (s > 34'sd2147483647) pos_step = 32'sh7fffffff;
    else if (s < -34'sd2147483648) pos_step = 32'sh80000000;
    else pos_step = s[31:0];
  endfunction

  ecou_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
    .clk(clk), .rst_n(rst_n), .req(creq), .rsp(crsp)
  );

  always_comb begin
    rnd4 = (prod_r + 50'sd8) >>> 4;
    psum = {{2{pitch_r[31]}}, pitch_r} + rnd4[33:0];
    pclip = psum;
    if (clamp_r && psum > DEG89) pclip = DEG89;
    else if (clamp_r && psum < -DEG89) pclip = -DEG89;
    yaw_ok = (yaw_t_r < DEG180) && (yaw_t_r >= -DEG180);
    pitch_ok = (pitch_t_r < DEG180) && (pitch_t_r >= -DEG180);
    uz_v = vmul(prod_r);
    zs = {4'b0, zoom_r} - {{2{scr_r[15]}}, scr_r};
    mvx = '0;
    mvy = '0;
    mvz = '0;
    mneg = dir_r[0];
    case (dir_r)
      DIR_FWD, DIR_BACK: begin
        mvx = fx_r;
        mvy = fy_r;
        mvz = fz_r;
      end
      DIR_LEFT, DIR_RIGHT: begin
        mvx = rx_r;
        mvz = rz_r;
        mneg = !dir_r[0];
      end
      DIR_UP, DIR_DOWN: mvy = VEC_ONE;
      default: mneg = 1'b0;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    mul_a = '0;
    mul_b = '0;
    creq.start = 1'b0;
    creq.angle = yaw_r;
    load_out = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          case (in_ch.command)
            CMD_ROTATE: state_nxt = ST_R_MX;
            CMD_MOVE:   state_nxt = (in_ch.direction > DIR_DOWN) ? ST_FIN : ST_M_V;
            CMD_SCROLL: state_nxt = ST_ZOOM;
            default:    state_nxt = ST_FIN;
          endcase
        end
      end
      ST_R_MX: begin
        mul_a = {xo_r[15], xo_r};
        mul_b = {17'b0, sens_r};
        state_nxt = ST_R_MY;
      end
      ST_R_MY: begin
        mul_a = {yo_r[15], yo_r};
        mul_b = {17'b0, sens_r};
        state_nxt = ST_R_ADD;
      end
      ST_R_ADD: state_nxt = ST_R_WRAP;
      ST_R_WRAP: begin
        if (yaw_ok && pitch_ok) state_nxt = ST_R_CY;
      end
      ST_R_CY: begin
        creq.start = 1'b1;
        state_nxt = ST_R_WY;
      end
      ST_R_WY: begin
        if (crsp.done) begin
          creq.start = 1'b1;
          creq.angle = pitch_r;
          state_nxt = ST_R_WP;
        end
      end
      ST_R_WP: begin
        if (crsp.done) state_nxt = ST_R_P0;
      end
      ST_R_P0: begin
        mul_a = {cy_r[15], cy_r};
        mul_b = {{17{cp_r[15]}}, cp_r};
        state_nxt = ST_R_P1;
      end
      ST_R_P1: begin
        mul_a = {sy_r[15], sy_r};
        mul_b = {{17{cp_r[15]}}, cp_r};
        state_nxt = ST_R_P2;
      end
      ST_R_P2: begin
        mul_a = {cy_r[15], cy_r};
        mul_b = {{17{sp_r[15]}}, sp_r};
        state_nxt = ST_R_P3;
      end
      ST_R_P3: begin
        mul_a = {sy_r[15], sy_r};
        mul_b = {{17{sp_r[15]}}, sp_r};
        state_nxt = ST_R_VEC;
      end
      ST_R_VEC: state_nxt = ST_FIN;
      ST_M_V: begin
        mul_a = {1'b0, speed_r};
        mul_b = {17'b0, dt_r};
        state_nxt = ST_M_X;
      end
      ST_M_X: begin
        mul_a = {mvx[15], mvx};
        mul_b = {1'b0, prod_r[31:0]};
        state_nxt = ST_M_Y;
      end
      ST_M_Y: begin
        mul_a = {mvy[15], mvy};
        mul_b = {1'b0, vel_r};
        state_nxt = ST_M_Z;
      end
      ST_M_Z: begin
        mul_a = {mvz[15], mvz};
        mul_b = {1'b0, vel_r};
        state_nxt = ST_M_W;
      end
      ST_M_W: state_nxt = ST_FIN;
      ST_ZOOM: state_nxt = ST_FIN;
      ST_FIN: begin
        if (!out_valid_r || out_ch.ready) begin
          load_out = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      speed_r <= SPEED_RESET;
      sens_r <= SENS_RESET;
      yaw_r <= YAW_RESET;
      pitch_r <= '0;
      pos_r[0] <= '0;
      pos_r[1] <= '0;
      pos_r[2] <= '0;
      fx_r <= -VEC_ONE;
      fy_r <= '0;
      fz_r <= '0;
      rx_r <= '0;
      rz_r <= -VEC_ONE;
      ux_r <= '0;
      uy_r <= VEC_ONE;
      uz_r <= '0;
      zoom_r <= ZOOM_MAX;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_ch.valid) begin
        case (cfg_ch.index)
          CFG_MOVE_SPEED: speed_r <= cfg_ch.data;
          CFG_LOOK_SENS:  sens_r <= cfg_ch.data;
          default: ;
        endcase
      end
      if (load_out) out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
      case (state_r)
        ST_R_WRAP: begin
          if (yaw_ok && pitch_ok) begin
            yaw_r <= yaw_t_r[31:0];
            pitch_r <= pitch_t_r[31:0];
          end
        end
        ST_R_VEC: begin
          fx_r <= tfx_r;
          fy_r <= sp_r;
          fz_r <= tfz_r;
          if (cp_r == 16'sd0) begin
            rx_r <= '0;
            rz_r <= '0;
            ux_r <= '0;
            uy_r <= '0;
            uz_r <= '0;
          end else if (!cp_r[15]) begin
            rx_r <= -sy_r;
            rz_r <= cy_r;
            ux_r <= -tux_r;
            uy_r <= cp_r;
            uz_r <= -uz_v;
          end else begin
            rx_r <= sy_r;
            rz_r <= -cy_r;
            ux_r <= tux_r;
            uy_r <= -cp_r;
            uz_r <= uz_v;
          end
        end
        ST_M_Y: pos_r[0] <= pos_step(pos_r[0], prod_r, mneg);
        ST_M_Z: pos_r[1] <= pos_step(pos_r[1], prod_r, mneg);
        ST_M_W: pos_r[2] <= pos_step(pos_r[2], prod_r, mneg);
        ST_ZOOM: begin
          if (zs < 18'sd256) zoom_r <= ZOOM_MIN;
          else if (zs > 18'sd11520) zoom_r <= ZOOM_MAX;
          else zoom_r <= zs[13:0];
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
    if (in_ch.valid && state_r == ST_IDLE) begin
      xo_r <= in_ch.x_offset;
      yo_r <= in_ch.y_offset;
      clamp_r <= in_ch.clamp_pitch;
      dir_r <= in_ch.direction;
      dt_r <= in_ch.delta_seconds;
      scr_r <= in_ch.scroll_amount;
    end
    case (state_r)
      ST_R_MY: dx_r <= rnd4[31:0];
      ST_R_ADD: begin
        yaw_t_r <= {{2{yaw_r[31]}}, yaw_r} + {{2{dx_r[31]}}, dx_r};
        pitch_t_r <= pclip;
      end
      ST_R_WRAP: begin
        if (yaw_t_r >= DEG180) yaw_t_r <= yaw_t_r - DEG360;
        else if (yaw_t_r < -DEG180) yaw_t_r <= yaw_t_r + DEG360;
        if (pitch_t_r >= DEG180) pitch_t_r <= pitch_t_r - DEG360;
        else if (pitch_t_r < -DEG180) pitch_t_r <= pitch_t_r + DEG360;
      end
      ST_R_WY: begin
        if (crsp.done) begin
          sy_r <= crsp.sin_v;
          cy_r <= crsp.cos_v;
        end
      end
      ST_R_WP: begin
        if (crsp.done) begin
          sp_r <= crsp.sin_v;
          cp_r <= crsp.cos_v;
        end
      end
      ST_R_P1: tfx_r <= vmul(prod_r);
      ST_R_P2: tfz_r <= vmul(prod_r);
      ST_R_P3: tux_r <= vmul(prod_r);
      ST_M_X: vel_r <= prod_r[31:0];
      default: ;
    endcase
    if (load_out) begin
      out_px_r <= pos_r[0];
      out_py_r <= pos_r[1];
      out_pz_r <= pos_r[2];
      out_fx_r <= fx_r;
      out_fy_r <= fy_r;
      out_fz_r <= fz_r;
      out_ux_r <= ux_r;
      out_uy_r <= uy_r;
      out_uz_r <= uz_r;
      out_zoom_r <= zoom_r;
      out_degen_r <= (rx_r == 16'sd0) && (rz_r == 16'sd0);
    end
  end

  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready = (state_r == ST_IDLE);
  assign out_ch.valid = out_valid_r;
  assign out_ch.pos_x = out_px_r;
  assign out_ch.pos_y = out_py_r;
  assign out_ch.pos_z = out_pz_r;
  assign out_ch.front_x = out_fx_r;
  assign out_ch.front_y = out_fy_r;
  assign out_ch.front_z = out_fz_r;
  assign out_ch.up_x = out_ux_r;
  assign out_ch.up_y = out_uy_r;
  assign out_ch.up_z = out_uz_r;
  assign out_ch.zoom_deg = out_zoom_r;
  assign out_ch.degenerate = out_degen_r;

  `ECOU_ASSERT_IMPL(a_zoom_range, 1'b1, zoom_r >= ZOOM_MIN && zoom_r <= ZOOM_MAX)
  `ECOU_ASSERT_IMPL(a_degen_up, out_valid_r && out_degen_r, {out_ux_r, out_uy_r, out_uz_r} == '0)
  `ECOU_ASSERT_NEXT(a_busy_after_accept, in_ch.valid && in_ch.ready, !in_ch.ready)
  `ECOU_ASSERT_IMPL(a_pitch_range, state_r == ST_IDLE, pitch_r < 32'sd11796480 && pitch_r >= -32'sd11796480)

endmodule
`default_nettype wire
